@@ src/sha_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Shared constants, types and round functions.
// ----------------------------------------------------------------------------
package sha_pkg;

  // Command codes
  typedef enum logic {CMD_ABSORB = 1'b0, CMD_FINISH = 1'b1} cmd_t;

  // Item passed from front to back through the queue
  typedef struct packed {
    logic       finish;
    logic [7:0] data;
  } qitem_t;

  // Back part states
  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_COMP, ST_EMIT
  } back_state_t;

  // Compression status
  typedef struct packed {
    logic busy;
    logic done;
  } comp_stat_t;

  // Padding marker byte and the byte position where the bit length starts
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};

  localparam logic [255:0] INIT_HASH_VEC = {
    INIT_HASH[0], INIT_HASH[1], INIT_HASH[2], INIT_HASH[3],
    INIT_HASH[4], INIT_HASH[5], INIT_HASH[6], INIT_HASH[7]};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

@@ src/sha_front.sv @@
// ----------------------------------------------------------------------------
// SHA-256 front
// Accepts stream items, classifies them and pushes them into a 4-entry queue.
// ----------------------------------------------------------------------------
module sha_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [8:0]    in_data,
  output sha_pkg::qitem_t q_item,
  output logic          q_valid,
  input  logic          q_pop
);
  import sha_pkg::*;

  qitem_t     fifo [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;
  logic       push;

  assign in_ready = (count != 3'd4);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 3'd0);
  assign q_item   = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr].finish <= (in_data[0] == CMD_FINISH);
      fifo[wr_ptr].data   <= in_data[8:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (q_pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + {2'b0, push} - {2'b0, q_pop};
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 3'd4)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst)
    (count == 3'd4) |-> !push)
    else $error("push into full queue");
endmodule

@@ src/sha_core.sv @@
// ----------------------------------------------------------------------------
// SHA-256 compression core
// Runs 64 rounds, one per cycle, with a 16-word rolling schedule.
// ----------------------------------------------------------------------------
module sha_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [511:0] block,
  input  logic [255:0] hash_in,
  output logic [255:0] hash_out,
  output sha_pkg::comp_stat_t stat
);
  import sha_pkg::*;

  logic [31:0] w [16];
  logic [31:0] v [8];
  logic [5:0]  rnd;
  logic        busy;
  logic        done;
  logic [31:0] t1, t2, s0, s1, wn, wcur;

  assign wcur = w[0];
  always_comb begin
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    wn = s1 + w[9] + s0 + w[0];
    t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
       + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[rnd] + wcur;
    t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
       + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  always_comb begin
    for (int i = 0; i < 8; i++)
      hash_out[255 - 32*i -: 32] = hash_in[255 - 32*i -: 32] + v[i];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < 16; i++) w[i] <= block[511 - 32*i -: 32];
      for (int i = 0; i < 8; i++) v[i] <= hash_in[255 - 32*i -: 32];
    end else if (busy) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wn;
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rnd  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rnd  <= '0;
      end else if (busy) begin
        rnd <= rnd + 6'd1;
        if (rnd == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign stat = '{busy: busy, done: done};

  assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("start while busy");
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");
  assert property (@(posedge clk) disable iff (rst)
    (busy && rnd == 6'd63) |=> done)
    else $error("missing done");
endmodule

@@ src/sha_back.sv @@
// ----------------------------------------------------------------------------
// SHA-256 back
// Collects bytes, pads, drives the compression core and emits the digest.
// ----------------------------------------------------------------------------
module sha_back (
  input  logic          clk,
  input  logic          rst,
  input  sha_pkg::qitem_t q_item,
  input  logic          q_valid,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [39:0]   out_data,
  output logic          out_last
);
  import sha_pkg::*;

  back_state_t  state, state_next;
  logic [511:0] blk, blk_next;
  logic [255:0] hash, hash_new;
  logic [5:0]   fill;
  logic [63:0]  msg_bits;
  logic         finishing, second;
  logic [2:0]   widx;
  logic         start;
  logic         take;
  comp_stat_t   cstat;

  sha_core u_core (
    .clk(clk), .rst(rst), .start(start), .block(blk),
    .hash_in(hash), .hash_out(hash_new), .stat(cstat));

  assign take  = (state == ST_IDLE) && q_valid;
  assign start = (state == ST_LOAD);

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    out_valid  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.finish || fill == 6'd63) state_next = ST_LOAD;
        end
      end
      ST_LOAD: state_next = ST_COMP;
      ST_COMP: begin
        if (cstat.done) begin
          if (second) state_next = ST_LOAD;
          else if (finishing) state_next = ST_EMIT;
          else state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready && widx == 3'd7) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Byte writes, padding and the length block are registered into blk ahead of the load
  always_comb begin
    blk_next = blk;
    if (take && !q_item.finish) begin
      blk_next[{~fill, 3'b111} -: 8] = q_item.data;
    end else if (take) begin
      for (int i = 0; i < 64; i++) begin
        if (6'(i) == fill) blk_next[511 - 8*i -: 8] = PAD_BYTE;
        else if (6'(i) > fill) blk_next[511 - 8*i -: 8] = 8'h00;
      end
      if (fill < LEN_POS) blk_next[63:0] = msg_bits;
    end else if (state == ST_COMP && cstat.done && second) begin
      blk_next = {448'd0, msg_bits};
    end
  end

  always_ff @(posedge clk) begin
    blk <= blk_next;
  end

  assign out_data = {5'd0, widx, hash[{~widx, 5'b11111} -: 32]};
  assign out_last = (widx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      msg_bits  <= '0;
      finishing <= 1'b0;
      second    <= 1'b0;
      widx      <= '0;
      hash      <= INIT_HASH_VEC;
    end else begin
      state <= state_next;
      if (take) begin
        if (q_item.finish) begin
          finishing <= 1'b1;
          second    <= (fill >= LEN_POS);
        end else begin
          fill     <= fill + 6'd1;
          msg_bits <= msg_bits + 64'd8;
        end
      end
      if (state == ST_COMP && cstat.done) begin
        hash   <= hash_new;
        second <= 1'b0;
      end
      if (state == ST_EMIT && out_ready) begin
        widx <= widx + 3'd1;
        if (widx == 3'd7) begin
          finishing <= 1'b0;
          fill      <= '0;
          msg_bits  <= '0;
          hash      <= INIT_HASH_VEC;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> finishing)
    else $error("digest out of finish");
  assert property (@(posedge clk) disable iff (rst) q_pop |-> state == ST_IDLE)
    else $error("pop outside idle");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && out_ready && widx == 3'd7) |=> widx == 3'd0)
    else $error("word index wrap");
endmodule

@@ src/sha256_stream_hasher_unit.sv @@
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-serial SHA-256 with finish command and digest word output.
// ----------------------------------------------------------------------------
//  channel | direction | tdata fields (low first)                 | tuser      | tlast
//  s_axis  | in        | data_byte[7:0]                           | command[0] | -
//  m_axis  | out       | digest_word[31:0], word_index[34:32]     | -          | last_word
//
// The back part takes one item per cycle from the queue while idle. Every 64th
// byte stalls it for a compression: a load step, 64 rounds and a fold into hash.
// Finish takes a pop plus one or two compressions, then eight words leave one
// per cycle while m_axis_tready is high.
// A 4-entry queue lets input continue while the back part compresses.
// rst is synchronous and returns hash state to the initial values.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tuser,   // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // digest_word, word_index
  output logic        m_axis_tlast
);
  import sha_pkg::*;

  qitem_t q_item;
  logic   q_valid, q_pop;

  // Hold classified items in the queue until the back part takes them
  sha_front u_front (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_data({s_axis_tdata, s_axis_tuser}), .q_item(q_item), .q_valid(q_valid),
    .q_pop(q_pop));

  // Advance compression and emit digest words
  sha_back u_back (
    .clk(clk), .rst(rst), .q_item(q_item), .q_valid(q_valid), .q_pop(q_pop),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_data(m_axis_tdata), .out_last(m_axis_tlast));

  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("output dropped while stalled");
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("output changed while stalled");
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[34:32] == 3'd7)))
    else $error("last word flag mismatch");
endmodule
